>>> rtl/core/tcw_pkg.sv
// Package with the shared types and fixed constants of the text console character writer.
package tcw_pkg;

    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int COL_IN_W     = 7;
    localparam int ROW_IN_W     = 5;
    localparam int CURSOR_OUT_W = 11;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;
    localparam logic              CMD_PUT      = 1'b0;
    localparam logic              CMD_READ     = 1'b1;

    typedef enum logic [1:0] {
        KIND_PUT,
        KIND_NEWLINE,
        KIND_READ
    } tcw_kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } tcw_state_t;

    typedef struct packed {
        tcw_kind_t         kind;
        logic [CHAR_W-1:0] character;
        logic [ATTR_W-1:0] attribute;
        logic              use_position;
    } tcw_cmd_t;

    typedef struct packed {
        logic clearing;
        logic scrolling;
    } tcw_status_t;

endpackage

>>> rtl/core/tcw_front.sv
// Front part: accepts items, applies the default attribute and resolves the addressed cell.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS),
    parameter int CELL_W  = $clog2(COLUMNS * ROWS)
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ATTR_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_command,
    input  logic [CHAR_W-1:0]   in_character,
    input  logic [ATTR_W-1:0]   in_attribute,
    input  logic                in_use_position,
    input  logic [COL_IN_W-1:0] in_column,
    input  logic [ROW_IN_W-1:0] in_row_index,
    input  logic                hold,
    input  logic                full,
    output logic                push,
    output tcw_cmd_t            cmd,
    output logic [COL_W-1:0]    col_idx,
    output logic [ROW_W-1:0]    row_idx,
    output logic [CELL_W-1:0]   cell_idx
);

    logic [ATTR_W-1:0] default_attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= ATTR_RESET;
        end
        else if (cfg_we)
        begin
            default_attr_reg <= cfg_wdata;
        end
    end

    assign in_ready = !full && !hold;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        if (in_command == CMD_READ)
        begin
            cmd.kind = KIND_READ;
        end
        else if (in_character == NEWLINE_CODE)
        begin
            cmd.kind = KIND_NEWLINE;
        end
        else
        begin
            cmd.kind = KIND_PUT;
        end
        cmd.character    = in_character;
        cmd.attribute    = (in_attribute == '0) ? default_attr_reg : in_attribute;
        cmd.use_position = in_use_position;

        if (int'(in_column) >= COLUMNS)
        begin
            col_idx = COL_W'(COLUMNS - 1);
        end
        else
        begin
            col_idx = COL_W'(in_column);
        end

        if (int'(in_row_index) >= ROWS)
        begin
            row_idx = ROW_W'(ROWS - 1);
        end
        else
        begin
            row_idx = ROW_W'(in_row_index);
        end

        cell_idx = CELL_W'(int'(row_idx) * COLUMNS + int'(col_idx));
    end

endmodule

>>> rtl/core/tcw_queue.sv
// Two-entry queue that decouples the front part from the back part.
module tcw_queue
    import tcw_pkg::*;
#(
    parameter int DATA_W = 32
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  rptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;

    assign full  = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

endmodule

>>> rtl/core/tcw_back.sv
// Back part: screen memory, cursor, clearing pass, row scroll and the result register.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS),
    parameter int CELL_W  = $clog2(COLUMNS * ROWS)
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  tcw_cmd_t                q_cmd,
    input  logic [COL_W-1:0]        q_col,
    input  logic [ROW_W-1:0]        q_row,
    input  logic [CELL_W-1:0]       q_cell,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CURSOR_OUT_W-1:0] out_cursor,
    output logic                    out_scrolled,
    output logic [CHAR_W-1:0]       out_character,
    output logic [ATTR_W-1:0]       out_attribute,
    output logic [CELL_W-1:0]       cursor,
    output tcw_status_t             status
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int KEEP       = CELL_COUNT - COLUMNS;
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int WORD_W     = CHAR_W + ATTR_W;

    tcw_state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [CELL_W-1:0] cur_cell_reg, cur_cell_next;
    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] out_cursor_reg, out_cursor_next;
    logic              out_scrolled_reg, out_scrolled_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [ATTR_W-1:0] out_attr_reg, out_attr_next;

    logic [WORD_W-1:0] mem [CELL_COUNT];
    logic [WORD_W-1:0] rdata_reg;
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [CNT_W-1:0]  rd_sum;
    logic [CNT_W-1:0]  wr_idx;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
    logic [CELL_W-1:0] pos_cell;
    logic [ROW_W:0]    row_step;
    logic [CNT_W-1:0]  cell_step;
    logic [CELL_W+CURSOR_OUT_W-1:0] cursor_ext;

    assign rd_sum = cnt_reg + CNT_W'(COLUMNS);
    assign wr_idx = cnt_reg - 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        cur_cell_next     = cur_cell_reg;
        out_valid_next    = out_ready ? 1'b0 : out_valid_reg;
        out_cursor_next   = out_cursor_reg;
        out_scrolled_next = out_scrolled_reg;
        out_char_next     = out_char_reg;
        out_attr_next     = out_attr_reg;
        q_pop             = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = cnt_reg[CELL_W-1:0];
        mem_raddr         = rd_sum[CELL_W-1:0];
        mem_wdata         = '0;
        pos_col           = q_cmd.use_position ? q_col : cur_col_reg;
        pos_row           = q_cmd.use_position ? q_row : cur_row_reg;
        pos_cell          = q_cmd.use_position ? q_cell : cur_cell_reg;
        row_step          = {1'b0, pos_row};
        cell_step         = CNT_W'(pos_cell);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (cnt_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty && (!out_valid_reg || out_ready))
                begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == KIND_READ)
                    begin
                        mem_raddr  = q_cell;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        if (q_cmd.kind == KIND_NEWLINE)
                        begin
                            cur_col_next = '0;
                            row_step     = {1'b0, pos_row} + 1'b1;
                            cell_step    = CNT_W'(pos_cell) - CNT_W'(pos_col)
                                           + CNT_W'(COLUMNS);
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_cell;
                            mem_wdata = {q_cmd.attribute, q_cmd.character};
                            cell_step = CNT_W'(pos_cell) + 1'b1;
                            if (pos_col == COL_W'(COLUMNS - 1))
                            begin
                                cur_col_next = '0;
                                row_step     = {1'b0, pos_row} + 1'b1;
                            end
                            else
                            begin
                                cur_col_next = pos_col + 1'b1;
                            end
                        end

                        if (row_step == (ROW_W + 1)'(ROWS))
                        begin
                            cur_row_next  = ROW_W'(ROWS - 1);
                            cur_cell_next = CELL_W'(cell_step - CNT_W'(COLUMNS));
                            cnt_next      = '0;
                            state_next    = ST_SCROLL;
                        end
                        else
                        begin
                            cur_row_next      = row_step[ROW_W-1:0];
                            cur_cell_next     = cell_step[CELL_W-1:0];
                            out_valid_next    = 1'b1;
                            out_cursor_next   = cell_step[CELL_W-1:0];
                            out_scrolled_next = 1'b0;
                            out_char_next     = '0;
                            out_attr_next     = '0;
                        end
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next    = 1'b1;
                out_cursor_next   = cur_cell_reg;
                out_scrolled_next = 1'b0;
                out_char_next     = rdata_reg[CHAR_W-1:0];
                out_attr_next     = rdata_reg[WORD_W-1:CHAR_W];
                state_next        = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // The cell read in one cycle is written one row up in the next.
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_idx[CELL_W-1:0];
                    mem_wdata = (wr_idx < CNT_W'(KEEP)) ? rdata_reg : '0;
                end
                if (cnt_reg == CNT_W'(CELL_COUNT))
                begin
                    cnt_next          = '0;
                    out_valid_next    = 1'b1;
                    out_cursor_next   = cur_cell_reg;
                    out_scrolled_next = 1'b1;
                    out_char_next     = '0;
                    out_attr_next     = '0;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_cell_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cur_cell_reg  <= cur_cell_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cursor_reg   <= out_cursor_next;
        out_scrolled_reg <= out_scrolled_next;
        out_char_reg     <= out_char_next;
        out_attr_reg     <= out_attr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign cursor_ext       = {{CURSOR_OUT_W{1'b0}}, out_cursor_reg};
    assign out_cursor       = cursor_ext[CURSOR_OUT_W-1:0];
    assign out_valid        = out_valid_reg;
    assign out_scrolled     = out_scrolled_reg;
    assign out_character    = out_char_reg;
    assign out_attribute    = out_attr_reg;
    assign cursor           = cur_cell_reg;
    assign status.clearing  = (state_reg == ST_CLEAR);
    assign status.scrolling = (state_reg == ST_SCROLL);

endmodule

>>> rtl/core/text_console_char_writer_core.sv
// Top level of the text console character writer: front part, queue and back part.
// A put passes the queue and the result register before m_tvalid rises; a read also passes
// the memory read register and holds the back part in its read state before it pops again.
// One put per cycle while m_tready takes each result; a put that scrolls holds the back part
// while the rows are copied up. Reset sets the cursor to the top left cell and the default
// attribute to 15, then a clearing pass zeroes the screen memory while no item is accepted.
module text_console_char_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [ATTR_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // character[7:0], attribute[15:8], use_position[16], column[23:17], row_index[28:24]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cursor_cell[10:0], scrolled[11], read_character[19:12], read_attribute[27:20]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CELL_W     = $clog2(COLUMNS * ROWS);
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int KEEP       = CELL_COUNT - COLUMNS;
    localparam int CMD_W      = $bits(tcw_cmd_t);
    localparam int Q_W        = CMD_W + COL_W + ROW_W + CELL_W;

    tcw_cmd_t          f_cmd, q_cmd;
    logic [COL_W-1:0]  f_col, q_col;
    logic [ROW_W-1:0]  f_row, q_row;
    logic [CELL_W-1:0] f_cell, q_cell;
    logic              f_push;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic [Q_W-1:0]    q_din;
    logic [Q_W-1:0]    q_dout;
    logic [CELL_W-1:0] cursor;
    tcw_status_t       status;

    logic [CURSOR_OUT_W-1:0] out_cursor;
    logic                    out_scrolled;
    logic [CHAR_W-1:0]       out_character;
    logic [ATTR_W-1:0]       out_attribute;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_command      (s_tuser),
        .in_character    (s_tdata[7:0]),
        .in_attribute    (s_tdata[15:8]),
        .in_use_position (s_tdata[16]),
        .in_column       (s_tdata[23:17]),
        .in_row_index    (s_tdata[28:24]),
        .hold            (status.clearing),
        .full            (q_full),
        .push            (f_push),
        .cmd             (f_cmd),
        .col_idx         (f_col),
        .row_idx         (f_row),
        .cell_idx        (f_cell)
    );

    assign q_din = {f_cmd, f_col, f_row, f_cell};
    assign {q_cmd, q_col, q_row, q_cell} = q_dout;

    tcw_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd),
        .q_col         (q_col),
        .q_row         (q_row),
        .q_cell        (q_cell),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_cursor    (out_cursor),
        .out_scrolled  (out_scrolled),
        .out_character (out_character),
        .out_attribute (out_attribute),
        .cursor        (cursor),
        .status        (status)
    );

    assign m_tdata = {4'b0, out_attribute, out_character, out_scrolled, out_cursor};

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (status.clearing || status.scrolling) |-> !m_tvalid)
        else $error("result offered during a clearing pass or scroll");

    a_scroll_leaves_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[11]) |-> (int'(cursor) >= KEEP))
        else $error("cursor not on the last row after a scroll");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cursor) < CELL_COUNT)
        else $error("cursor beyond the last cell");

endmodule
